// ===== hdl/gic_pkg.sv =====
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants for the gamepad input conditioner
// Request/response word layouts, register indexes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gic_pkg;

   localparam int ANGLE_ITERATIONS_DEF = 16;
   localparam int ATAN_ENTRIES         = 24;
   localparam int CSR_IDX_W            = 2;
   localparam int CSR_DATA_W           = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_THR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_THR  = 2'd2;

   localparam logic [14:0] DEAD_ZONE_RESET = 15'd8192;
   localparam logic [7:0]  THR_RESET       = 8'd128;

   // half turn in 2^-16 degree units
   localparam logic signed [35:0] HALF_TURN = 36'sd11796480;

   typedef struct packed {
      logic [15:0]        buttons;
      logic [7:0]         left_trigger;
      logic [7:0]         right_trigger;
      logic signed [15:0] left_stick_x;
      logic signed [15:0] left_stick_y;
      logic signed [15:0] right_stick_x;
      logic signed [15:0] right_stick_y;
   } req_word_type;

   typedef struct packed {
      logic [15:0]        buttons_held;
      logic [15:0]        buttons_pressed_edge;
      logic [3:0]         trigger_flags;
      logic signed [15:0] left_out_x;
      logic signed [15:0] left_out_y;
      logic [15:0]        left_magnitude;
      logic signed [15:0] left_angle;
      logic signed [15:0] right_out_x;
      logic signed [15:0] right_out_y;
      logic [15:0]        right_magnitude;
      logic signed [15:0] right_angle;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [15:0]        magnitude;
      logic signed [15:0] angle;
   } stick_out_type;

   function automatic logic [21:0] atan_entry(input logic [4:0] i);
      logic [21:0] v;
      unique case (i)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/gic_stick_lane.sv =====
// ----------------------------------------------------------------------------
// gic_stick_lane: one stick lane
// Dead zone test, bit-serial square root, restoring divide for the rescaled
// length and a CORDIC for the angle, one step per cycle each.
// ----------------------------------------------------------------------------
module gic_stick_lane #(
   parameter int ANGLE_ITERATIONS = gic_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [15:0]    stick_x,
   input  logic signed [15:0]    stick_y,
   input  logic [14:0]           radius,
   output logic                  done,
   output gic_pkg::stick_out_type result
);

   localparam int NSTEP = (ANGLE_ITERATIONS < gic_pkg::ATAN_ENTRIES) ?
                          ANGLE_ITERATIONS : gic_pkg::ATAN_ENTRIES;

   // fixed schedule: sq, cmp, 17 root, load, 32 divide, NSTEP cordic, finish
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SQ    = 7'b0000010,
      S_CMP   = 7'b0000100,
      S_ROOT  = 7'b0001000,
      S_LOAD  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_CORD  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic signed [15:0] x_ff, x_in, y_ff, y_in;
   logic [14:0] r_ff, r_in;
   logic [31:0] sx_ff, sx_in, sy_ff, sy_in, rr_ff, rr_in;
   logic [32:0] s_ff, s_in;          // radicand remainder
   logic [32:0] root_ff, root_in;
   logic [32:0] bit_ff, bit_in;
   logic [31:0] quo_ff, quo_in;      // dividend shifts out, quotient in
   logic [15:0] rem_ff, rem_in;
   logic signed [25:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [35:0] z_ff, z_in;
   logic inside_ff, inside_in;
   logic done_ff, done_in;
   gic_pkg::stick_out_type res_ff, res_in;

   logic [16:0] len;
   logic [15:0] dvs;
   logic [16:0] trial;
   logic        ge;
   logic signed [25:0] dx, dy, x256, y256;
   logic signed [35:0] atan_z;
   logic signed [31:0] xx, yy;
   logic [29:0] r_sq;
   logic [35:0] zmag;
   logic [42:0] hprod;
   logic [26:0] hval;
   logic [15:0] hcl;
   logic [31:0] ssum;
   logic [32:0] sb;

   assign len    = root_ff[16:0];
   assign dvs    = 16'd32767 - {1'b0, r_ff};
   assign trial  = {rem_ff, quo_ff[31]};
   assign ge     = trial >= {1'b0, dvs};
   assign dx     = cy_ff >>> cnt_ff;
   assign dy     = cx_ff >>> cnt_ff;
   assign x256   = {{2{x_ff[15]}}, x_ff, 8'd0};
   assign y256   = {{2{y_ff[15]}}, y_ff, 8'd0};
   assign atan_z = $signed(36'(gic_pkg::atan_entry(cnt_ff)));
   assign xx     = x_ff * x_ff;
   assign yy     = y_ff * y_ff;
   assign r_sq   = r_ff * r_ff;
   assign zmag   = z_ff[35] ? 36'(-z_ff) : 36'(z_ff);
   assign hprod  = 43'(zmag) * 43'd100 + 43'd32768;
   assign hval   = hprod[42:16];
   assign hcl    = (hval > 27'd18000) ? 16'd18000 : hval[15:0];
   assign ssum   = sx_ff + sy_ff;
   assign sb     = root_ff + bit_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      r_in      = r_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      rr_in     = rr_ff;
      s_in      = s_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      z_in      = z_ff;
      inside_in = inside_ff;
      done_in   = 1'b0;
      res_in    = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in     = stick_x;
               y_in     = stick_y;
               r_in     = radius;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            sx_in    = xx;
            sy_in    = yy;
            rr_in    = {2'b0, r_sq};
            state_in = S_CMP;
         end
         S_CMP: begin
            inside_in = (ssum <= rr_ff);
            s_in      = {1'b0, ssum};
            root_in   = '0;
            bit_in    = 33'h1_0000_0000;
            cnt_in    = '0;
            state_in  = S_ROOT;
         end
         S_ROOT: begin
            if (s_ff >= sb) begin
               s_in    = s_ff - sb;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               state_in = S_LOAD;
               cnt_in   = '0;
            end
         end
         S_LOAD: begin
            // dividend (len - r) << 15; CORDIC start point set up alongside
            quo_in = {len - {2'b0, r_ff}, 15'd0};
            rem_in = '0;
            cnt_in = '0;
            if (x_ff[15]) begin
               z_in  = y_ff[15] ? -gic_pkg::HALF_TURN : gic_pkg::HALF_TURN;
               cx_in = -x256;
               cy_in = -y256;
            end else begin
               z_in  = '0;
               cx_in = x256;
               cy_in = y256;
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
            quo_in = {quo_ff[30:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_CORD;
               cnt_in   = '0;
            end
         end
         S_CORD: begin
            if (cnt_ff < 5'(NSTEP)) begin
               cnt_in = cnt_ff + 5'd1;
               if (cy_ff > 26'sd0) begin
                  cx_in = cx_ff + dx;
                  cy_in = cy_ff - dy;
                  z_in  = z_ff + atan_z;
               end else begin
                  cx_in = cx_ff - dx;
                  cy_in = cy_ff + dy;
                  z_in  = z_ff - atan_z;
               end
            end else begin
               state_in = S_IDLE;
               done_in  = 1'b1;
               if (inside_ff) begin
                  res_in = '0;
               end else begin
                  res_in.out_x     = x_ff;
                  res_in.out_y     = y_ff;
                  res_in.magnitude = (r_ff == 15'h7FFF || quo_ff > 32'd65535) ?
                                     16'hFFFF : quo_ff[15:0];
                  res_in.angle     = z_ff[35] ? -$signed(hcl) : $signed(hcl);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      r_ff      <= r_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      rr_ff     <= rr_in;
      s_ff      <= s_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      z_ff      <= z_in;
      inside_ff <= inside_in;
      res_ff    <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

   property p_done_pulse;
      @(posedge clock) disable iff (reset) done |=> !done;
   endproperty
   a_done_pulse: assert property (p_done_pulse) else $error("done held");

   property p_inside_zero;
      @(posedge clock) disable iff (reset)
         (done && inside_ff) |-> (result.magnitude == 16'd0);
   endproperty
   a_inside_zero: assert property (p_inside_zero) else $error("dead zone leak");

   property p_angle_range;
      @(posedge clock) disable iff (reset)
         done |-> (result.angle <= 16'sd18000 && result.angle >= -16'sd18000);
   endproperty
   a_angle_range: assert property (p_angle_range) else $error("angle range");

endmodule

// ===== hdl/gamepad_input_conditioner.sv =====
// ----------------------------------------------------------------------------
// gamepad_input_conditioner: gamepad poll sample conditioning, top level
// Each word passes square, compare, 17 root steps, load, 32 divide steps,
// the CORDIC steps, finish and the response register before the response is
// valid. One word in flight; a new word is taken the cycle after the response
// goes, so the block never takes a new word before the last one is through.
// Both stick lanes run side by side; buttons and triggers merge at the end.
// Synchronous active-high reset clears the previous-sample state and loads
// register defaults (radius 8192, thresholds 128); no clearing pass.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner #(
   parameter int ANGLE_ITERATIONS = gic_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  gic_pkg::req_word_type              req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output gic_pkg::rsp_word_type              rsp_word,
   input  logic                               csr_write,
   input  logic [gic_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gic_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [14:0] radius_ff;
   logic [7:0]  lthr_ff, rthr_ff;
   logic [15:0] prev_btn_ff;
   logic [7:0]  prev_lt_ff, prev_rt_ff;
   logic        busy_ff;
   logic        rsp_valid_ff;
   logic [15:0] held_ff;
   gic_pkg::rsp_word_type  rsp_ff;
   logic [15:0] edge_ff;
   logic [3:0]  flags_ff;

   logic start, ldone, rdone;
   gic_pkg::stick_out_type lres, rres;
   logic lp, rp;

   // a new word waits until the previous response has been taken
   assign req_ready = !busy_ff && !rsp_valid_ff;
   assign start     = req_valid && req_ready;

   assign lp = req_word.left_trigger  > lthr_ff;
   assign rp = req_word.right_trigger > rthr_ff;

   gic_stick_lane #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_left (
      .clock(clock), .reset(reset), .start(start),
      .stick_x(req_word.left_stick_x), .stick_y(req_word.left_stick_y),
      .radius(radius_ff), .done(ldone), .result(lres));

   gic_stick_lane #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_right (
      .clock(clock), .reset(reset), .start(start),
      .stick_x(req_word.right_stick_x), .stick_y(req_word.right_stick_y),
      .radius(radius_ff), .done(rdone), .result(rres));

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= gic_pkg::DEAD_ZONE_RESET;
         lthr_ff      <= gic_pkg::THR_RESET;
         rthr_ff      <= gic_pkg::THR_RESET;
         prev_btn_ff  <= '0;
         prev_lt_ff   <= '0;
         prev_rt_ff   <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               gic_pkg::CSR_DEAD_ZONE: radius_ff <= csr_data[14:0];
               gic_pkg::CSR_LEFT_THR:  lthr_ff   <= csr_data[7:0];
               gic_pkg::CSR_RIGHT_THR: rthr_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
         if (start) begin
            // buttons and triggers settle at once; state moves to this sample
            held_ff     <= req_word.buttons;
            edge_ff     <= req_word.buttons & ~prev_btn_ff;
            flags_ff    <= {rp && prev_rt_ff < rthr_ff, rp,
                            lp && prev_lt_ff < lthr_ff, lp};
            prev_btn_ff <= req_word.buttons;
            prev_lt_ff  <= req_word.left_trigger;
            prev_rt_ff  <= req_word.right_trigger;
            busy_ff     <= 1'b1;
         end
         // both lanes run the same schedule, so they finish together
         if (busy_ff && ldone) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_ff.buttons_held         <= held_ff;
            rsp_ff.buttons_pressed_edge <= edge_ff;
            rsp_ff.trigger_flags        <= flags_ff;
            rsp_ff.left_out_x           <= lres.out_x;
            rsp_ff.left_out_y           <= lres.out_y;
            rsp_ff.left_magnitude       <= lres.magnitude;
            rsp_ff.left_angle           <= lres.angle;
            rsp_ff.right_out_x          <= rres.out_x;
            rsp_ff.right_out_y          <= rres.out_y;
            rsp_ff.right_magnitude      <= rres.magnitude;
            rsp_ff.right_angle          <= rres.angle;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   property p_lanes_sync;
      @(posedge clock) disable iff (reset) ldone == rdone;
   endproperty
   a_lanes_sync: assert property (p_lanes_sync) else $error("lanes out of step");

   property p_no_start_busy;
      @(posedge clock) disable iff (reset) start |=> busy_ff;
   endproperty
   a_no_start_busy: assert property (p_no_start_busy) else $error("busy lost");

   property p_done_when_busy;
      @(posedge clock) disable iff (reset) ldone |-> busy_ff;
   endproperty
   a_done_when_busy: assert property (p_done_when_busy) else $error("stray done");

endmodule
